[src/nlp_pkg.sv]
// nlp_pkg: shared types and codes of the numeric literal parser.
// Used by front, queue, back, top and checker; depends on nothing.
`timescale 1ns / 1ps

package nlp_pkg;

   // result kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_UINT = 2'd1;
   localparam logic [1:0] KIND_NINT = 2'd2;
   localparam logic [1:0] KIND_FRAC = 2'd3;

   // suffix codes
   localparam logic [1:0] SFX_NONE = 2'd0;
   localparam logic [1:0] SFX_KILO = 2'd1;
   localparam logic [1:0] SFX_MEGA = 2'd2;
   localparam logic [1:0] SFX_GIGA = 2'd3;

   // one classified character, as it travels from the front to the back
   typedef struct packed {
      logic        is_white;
      logic        is_nul;
      logic        is_minus;
      logic        is_plus;
      logic        is_dot;
      logic        is_zero;
      logic        is_dec;
      logic        is_oct;
      logic        is_bin;
      logic        is_hex;
      logic        is_x;
      logic        is_b;
      logic        is_i;
      logic [1:0]  sfx;
      logic [3:0]  digit;
      logic [31:0] pos;
   } char_info_type;

endpackage

[src/nlp_req_if.sv]
// nlp_req_if: character channel of the numeric literal parser.
// Carries valid, ready and one 8-bit character; no dependencies.
`timescale 1ns / 1ps

interface nlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

[src/nlp_rsp_if.sv]
// nlp_rsp_if: result channel of the numeric literal parser.
// Carries valid, ready and the parsed number fields; no dependencies.
`timescale 1ns / 1ps

interface nlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        negative;
   logic [63:0] magnitude;
   logic [7:0]  frac_digits;
   logic [31:0] end_position;
   logic        overflow;

   modport source (output valid, output kind, output negative, output magnitude,
                   output frac_digits, output end_position, output overflow,
                   input ready);
   modport sink   (input valid, input kind, input negative, input magnitude,
                   input frac_digits, input end_position, input overflow,
                   output ready);
endinterface

[src/nlp_front.sv]
// nlp_front: accepts characters, classifies them and stamps stream positions.
// Depends on nlp_pkg and nlp_req_if.
`timescale 1ns / 1ps

module nlp_front (
   input  logic                  clock,
   input  logic                  reset,
   nlp_req_if.sink               req,
   output logic                  push_valid,
   output nlp_pkg::char_info_type push_data,
   input  logic                  push_ready
);

   logic [31:0] pos_ff;
   logic [31:0] pos_in;
   logic [7:0]  c;
   logic        lower_hex;
   logic        upper_hex;

   assign c         = req.char_code;
   assign req.ready = push_ready;
   assign push_valid = req.valid;

   assign lower_hex = (c >= 8'h61) && (c <= 8'h66);
   assign upper_hex = (c >= 8'h41) && (c <= 8'h46);

   always_comb begin
      push_data          = '0;
      push_data.is_white = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                           (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
      push_data.is_nul   = (c == 8'h00);
      push_data.is_minus = (c == 8'h2D);
      push_data.is_plus  = (c == 8'h2B);
      push_data.is_dot   = (c == 8'h2E);
      push_data.is_zero  = (c == 8'h30);
      push_data.is_dec   = (c >= 8'h30) && (c <= 8'h39);
      push_data.is_oct   = (c >= 8'h30) && (c <= 8'h37);
      push_data.is_bin   = (c == 8'h30) || (c == 8'h31);
      push_data.is_hex   = push_data.is_dec || lower_hex || upper_hex;
      push_data.is_x     = (c == 8'h78) || (c == 8'h58);
      push_data.is_b     = (c == 8'h62) || (c == 8'h42);
      push_data.is_i     = (c == 8'h69) || (c == 8'h49);
      if ((c == 8'h6B) || (c == 8'h4B)) begin
         push_data.sfx = nlp_pkg::SFX_KILO;
      end else if ((c == 8'h6D) || (c == 8'h4D)) begin
         push_data.sfx = nlp_pkg::SFX_MEGA;
      end else if ((c == 8'h67) || (c == 8'h47)) begin
         push_data.sfx = nlp_pkg::SFX_GIGA;
      end else begin
         push_data.sfx = nlp_pkg::SFX_NONE;
      end
      if (lower_hex) begin
         push_data.digit = 4'(c - 8'h57);
      end else if (upper_hex) begin
         push_data.digit = 4'(c - 8'h37);
      end else begin
         push_data.digit = c[3:0];
      end
      push_data.pos = pos_ff;
   end

   // position of every accepted character, wrapping
   assign pos_in = (req.valid && push_ready) ? pos_ff + 32'd1 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

[src/nlp_queue.sv]
// nlp_queue: two-entry queue of classified characters between front and back.
// Depends on nlp_pkg.
`timescale 1ns / 1ps

module nlp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  nlp_pkg::char_info_type push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output nlp_pkg::char_info_type pop_data,
   input  logic                   pop_ready
);

   nlp_pkg::char_info_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && !pop |=> count_ff == 2'd2)
      else $error("full queue lost an entry");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

[src/nlp_back.sv]
// nlp_back: parse state machine, accumulator, suffix scaling and result register.
// Depends on nlp_pkg and nlp_rsp_if.
`timescale 1ns / 1ps

module nlp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  nlp_pkg::char_info_type pop_data,
   output logic                   pop_ready,
   nlp_rsp_if.source              rsp
);

   typedef enum logic [11:0] {
      ST_INIT      = 12'b0000_0000_0001,
      ST_SIGN      = 12'b0000_0000_0010,
      ST_ZERO_PT   = 12'b0000_0000_0100,
      ST_INIT_ZERO = 12'b0000_0000_1000,
      ST_DEC       = 12'b0000_0001_0000,
      ST_BIN       = 12'b0000_0010_0000,
      ST_OCT       = 12'b0000_0100_0000,
      ST_HEX       = 12'b0000_1000_0000,
      ST_FRAC      = 12'b0001_0000_0000,
      ST_END_INT   = 12'b0010_0000_0000,
      ST_END_FRAC  = 12'b0100_0000_0000,
      ST_SCALE     = 12'b1000_0000_0000
   } phase_type;

   phase_type   state_ff, state_in, state_n;
   logic [63:0] acc_ff, acc_in, acc_n;
   logic [7:0]  frac_ff, frac_in, frac_n;
   logic        minus_ff, minus_in, minus_n;
   logic [1:0]  sfx_ff, sfx_in, sfx_n;
   logic        wrap_ff, wrap_in, wrap_n;
   logic [1:0]  cnt_ff, cnt_in, cnt_n;
   logic [1:0]  kind_ff, kind_in, kind_n;
   logic [31:0] endpos_ff, endpos_in, endpos_n;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic        out_neg_ff, out_neg_in;
   logic [63:0] out_mag_ff, out_mag_in;
   logic [7:0]  out_frac_ff, out_frac_in;
   logic [31:0] out_end_ff, out_end_in;
   logic        out_ovf_ff, out_ovf_in;

   nlp_pkg::char_info_type ch;
   logic        emit, res_emit, step, fire, out_free;
   logic [1:0]  res_kind;
   logic [31:0] res_end;
   logic [67:0] acc_x, mac;
   logic [73:0] acc_k, k1000;
   logic [93:0] acc_b, bshift;
   logic        int_digit;
   logic [1:0]  int_kind;

   assign ch       = pop_data;
   assign out_free = !out_valid_ff || rsp.ready;

   // shift-add datapath: digit accumulate, times 1000, binary suffix shift
   assign acc_x = {4'b0, acc_ff};
   assign acc_k = {10'b0, acc_ff};
   assign acc_b = {30'b0, acc_ff};
   assign k1000 = (acc_k << 10) - (acc_k << 4) - (acc_k << 3);

   always_comb begin
      if (state_ff == ST_BIN) begin
         mac = (acc_x << 1) + {64'b0, ch.digit};
      end else if (state_ff == ST_OCT) begin
         mac = (acc_x << 3) + {64'b0, ch.digit};
      end else if (state_ff == ST_HEX) begin
         mac = (acc_x << 4) + {64'b0, ch.digit};
      end else begin
         mac = (acc_x << 3) + (acc_x << 1) + {64'b0, ch.digit};
      end
   end

   always_comb begin
      case (sfx_ff)
         nlp_pkg::SFX_KILO: bshift = acc_b << 10;
         nlp_pkg::SFX_MEGA: bshift = acc_b << 20;
         default:           bshift = acc_b << 30;
      endcase
   end

   assign int_kind  = minus_ff ? nlp_pkg::KIND_NINT : nlp_pkg::KIND_UINT;
   assign int_digit = ((state_ff == ST_DEC) && ch.is_dec) ||
                      ((state_ff == ST_BIN) && ch.is_bin) ||
                      ((state_ff == ST_OCT) && ch.is_oct) ||
                      ((state_ff == ST_HEX) && ch.is_hex);

   // next phase for one character (or one scaling step)
   always_comb begin
      state_n  = state_ff;
      acc_n    = acc_ff;
      frac_n   = frac_ff;
      minus_n  = minus_ff;
      sfx_n    = sfx_ff;
      wrap_n   = wrap_ff;
      cnt_n    = cnt_ff;
      kind_n   = kind_ff;
      endpos_n = endpos_ff;
      emit     = 1'b0;
      res_kind = nlp_pkg::KIND_NONE;
      res_end  = ch.pos;
      unique case (state_ff)
         ST_INIT: begin
            if (ch.is_minus) begin
               minus_n = 1'b1;
               state_n = ST_SIGN;
            end else if (ch.is_plus) begin
               state_n = ST_SIGN;
            end else if (ch.is_dot) begin
               state_n = ST_FRAC;
            end else if (ch.is_zero) begin
               state_n = ST_INIT_ZERO;
            end else if (ch.is_dec) begin
               acc_n   = {60'b0, ch.digit};
               state_n = ST_DEC;
            end else if (!ch.is_white) begin
               emit = 1'b1;
            end
         end
         ST_SIGN: begin
            if (ch.is_zero) begin
               state_n = ST_ZERO_PT;
            end else if (ch.is_dot) begin
               state_n = ST_FRAC;
            end else if (ch.is_dec) begin
               acc_n   = {60'b0, ch.digit};
               state_n = ST_DEC;
            end else begin
               emit = 1'b1;
            end
         end
         ST_ZERO_PT: begin
            if (ch.is_dot) begin
               state_n = ST_FRAC;
            end else if (!ch.is_zero) begin
               emit = 1'b1;
            end
         end
         ST_INIT_ZERO: begin
            if (ch.is_x) begin
               state_n = ST_HEX;
            end else if (ch.is_b) begin
               state_n = ST_BIN;
            end else if (ch.is_dot) begin
               state_n = ST_FRAC;
            end else if (ch.is_nul) begin
               emit     = 1'b1;
               res_kind = nlp_pkg::KIND_UINT;
            end else if (ch.sfx != nlp_pkg::SFX_NONE) begin
               sfx_n   = ch.sfx;
               state_n = ST_END_INT;
            end else if (ch.is_oct) begin
               acc_n   = {60'b0, ch.digit};
               state_n = ST_OCT;
            end else begin
               emit = 1'b1;
            end
         end
         ST_DEC, ST_BIN, ST_OCT, ST_HEX: begin
            if (int_digit) begin
               acc_n  = mac[63:0];
               wrap_n = wrap_ff || (mac[67:64] != 4'd0);
            end else if ((state_ff == ST_DEC) && ch.is_dot) begin
               state_n = ST_FRAC;
            end else if (ch.sfx != nlp_pkg::SFX_NONE) begin
               sfx_n   = ch.sfx;
               state_n = ST_END_INT;
            end else if (ch.is_white || ch.is_nul) begin
               emit     = 1'b1;
               res_kind = int_kind;
            end else begin
               emit = 1'b1;
            end
         end
         ST_FRAC: begin
            if (ch.is_dec) begin
               acc_n  = mac[63:0];
               wrap_n = wrap_ff || (mac[67:64] != 4'd0);
               frac_n = (frac_ff != 8'hFF) ? frac_ff + 8'd1 : frac_ff;
            end else if (ch.sfx != nlp_pkg::SFX_NONE) begin
               sfx_n   = ch.sfx;
               state_n = ST_END_FRAC;
            end else if (ch.is_white || ch.is_nul) begin
               emit     = 1'b1;
               res_kind = nlp_pkg::KIND_FRAC;
            end else begin
               emit = 1'b1;
            end
         end
         ST_END_INT, ST_END_FRAC: begin
            kind_n = (state_ff == ST_END_FRAC) ? nlp_pkg::KIND_FRAC : int_kind;
            if (ch.is_i) begin
               acc_n    = bshift[63:0];
               wrap_n   = wrap_ff || (bshift[93:64] != 30'd0);
               emit     = 1'b1;
               res_kind = kind_n;
               res_end  = ch.pos + 32'd1;
            end else begin
               // first times-1000 step now, the rest in the scaling phase
               acc_n  = k1000[63:0];
               wrap_n = wrap_ff || (k1000[73:64] != 10'd0);
               if (sfx_ff == nlp_pkg::SFX_KILO) begin
                  emit     = 1'b1;
                  res_kind = kind_n;
               end else begin
                  cnt_n    = 2'(sfx_ff - 2'd1);
                  endpos_n = ch.pos;
                  state_n  = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            acc_n  = k1000[63:0];
            wrap_n = wrap_ff || (k1000[73:64] != 10'd0);
            cnt_n  = 2'(cnt_ff - 2'd1);
            if (cnt_ff == 2'd1) begin
               emit     = 1'b1;
               res_kind = kind_ff;
               res_end  = endpos_ff;
            end
         end
         default: begin
            state_n = ST_INIT;
         end
      endcase
   end

   // handshake with the queue and the result register
   assign pop_ready = (state_ff != ST_SCALE) && (!emit || out_free);
   assign step      = (state_ff == ST_SCALE) ? (cnt_ff != 2'd1 || out_free)
                                              : (pop_valid && pop_ready);
   assign res_emit  = emit;
   assign fire      = step && res_emit;

   always_comb begin
      if (fire) begin
         state_in  = ST_INIT;
         acc_in    = '0;
         frac_in   = '0;
         minus_in  = 1'b0;
         sfx_in    = nlp_pkg::SFX_NONE;
         wrap_in   = 1'b0;
         cnt_in    = '0;
         kind_in   = nlp_pkg::KIND_NONE;
         endpos_in = endpos_ff;
      end else if (step) begin
         state_in  = state_n;
         acc_in    = acc_n;
         frac_in   = frac_n;
         minus_in  = minus_n;
         sfx_in    = sfx_n;
         wrap_in   = wrap_n;
         cnt_in    = cnt_n;
         kind_in   = kind_n;
         endpos_in = endpos_n;
      end else begin
         state_in  = state_ff;
         acc_in    = acc_ff;
         frac_in   = frac_ff;
         minus_in  = minus_ff;
         sfx_in    = sfx_ff;
         wrap_in   = wrap_ff;
         cnt_in    = cnt_ff;
         kind_in   = kind_ff;
         endpos_in = endpos_ff;
      end
   end

   // result register
   assign out_valid_in = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   assign out_kind_in  = res_kind;
   assign out_neg_in   = (res_kind != nlp_pkg::KIND_NONE) && minus_ff;
   assign out_mag_in   = (res_kind != nlp_pkg::KIND_NONE) ? acc_n : 64'd0;
   assign out_frac_in  = (res_kind == nlp_pkg::KIND_FRAC) ? frac_ff : 8'd0;
   assign out_end_in   = res_end;
   assign out_ovf_in   = (res_kind != nlp_pkg::KIND_NONE) && wrap_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         acc_ff       <= '0;
         frac_ff      <= '0;
         minus_ff     <= 1'b0;
         sfx_ff       <= nlp_pkg::SFX_NONE;
         wrap_ff      <= 1'b0;
         cnt_ff       <= '0;
         kind_ff      <= nlp_pkg::KIND_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         minus_ff     <= minus_in;
         sfx_ff       <= sfx_in;
         wrap_ff      <= wrap_in;
         cnt_ff       <= cnt_in;
         kind_ff      <= kind_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      endpos_ff <= endpos_in;
      if (fire) begin
         out_kind_ff <= out_kind_in;
         out_neg_ff  <= out_neg_in;
         out_mag_ff  <= out_mag_in;
         out_frac_ff <= out_frac_in;
         out_end_ff  <= out_end_in;
         out_ovf_ff  <= out_ovf_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_kind_ff;
   assign rsp.negative     = out_neg_ff;
   assign rsp.magnitude    = out_mag_ff;
   assign rsp.frac_digits  = out_frac_ff;
   assign rsp.end_position = out_end_ff;
   assign rsp.overflow     = out_ovf_ff;

   a_scale_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |-> cnt_ff != 2'd0)
      else $error("scaling phase with no steps left");

   a_scale_no_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |-> !pop_ready)
      else $error("character taken during scaling");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind == nlp_pkg::KIND_NONE |->
         rsp.magnitude == 64'd0 && !rsp.overflow && !rsp.negative)
      else $error("rejection carries number fields");

   a_frac_only: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind != nlp_pkg::KIND_FRAC |-> rsp.frac_digits == 8'd0)
      else $error("fraction digits on an integer result");

   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      fire |=> state_ff == ST_INIT && acc_ff == 64'd0 && !wrap_ff)
      else $error("number state not cleared after a result");

endmodule

[src/numeric_literal_parser.sv]
// numeric_literal_parser: ASCII number literal parser, top level.
// Depends on nlp_pkg, nlp_req_if, nlp_rsp_if, nlp_front, nlp_queue, nlp_back.
//
// Usage:
//  - req_if carries one character per transfer (char_code, 0 = NUL). rsp_if
//    carries one parsed number per transfer: kind, negative, magnitude,
//    frac_digits, end_position and overflow. A result is sent only on the
//    character that ends or rejects a number; other characters send nothing.
//  - Throughput is one character per cycle unless suffix scaling or a pending
//    result stalls it. A decimal suffix reuses the times-1000 shift-add unit:
//    k needs no scaling step, m and g add steps that stall the input (ready low
//    while the queue is full) unless the sender left gaps for the queue.
//  - The deciding character passes through the queue to the parse state
//    machine, whose result register loads when it is popped; suffix
//    scaling and waits behind a queued character delay the result.
//  - Backpressure: when rsp_if.ready is low the result register holds;
//    characters that produce no result keep flowing until a second result
//    is due, then the queue fills and req_if.ready drops.
//  - Reset (synchronous, active high) restarts parsing, zeroes the stream
//    position counter and drops any queued characters and pending result.
`timescale 1ns / 1ps

module numeric_literal_parser (
   input  logic      clock,
   input  logic      reset,
   nlp_req_if.sink   req_if,
   nlp_rsp_if.source rsp_if
);

   nlp_pkg::char_info_type push_data;
   nlp_pkg::char_info_type pop_data;
   logic                   push_valid, push_ready;
   logic                   pop_valid, pop_ready;

   // classify and stamp position
   nlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // decouples character intake from parsing and scaling
   nlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // parse, accumulate, scale and hold the result
   nlp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_if)
   );

endmodule

[sim/nlp_tb_pkg.sv]
// nlp_tb_pkg: character codes shared by the parser testbench files.
// No dependencies; used by nlp_number_checker and tb_top.
`timescale 1ns / 1ps

package nlp_tb_pkg;

   localparam logic [7:0] NUL   = 8'h00;
   localparam logic [7:0] VTAB  = 8'h0B;
   localparam logic [7:0] FFEED = 8'h0C;

endpackage

[sim/nlp_number_checker.sv]
// nlp_number_checker: watches both parser channels, predicts every parsed
// number and compares it with what the parser sends. Depends on nlp_pkg,
// nlp_tb_pkg, nlp_req_if and nlp_rsp_if.
`timescale 1ns / 1ps

module nlp_number_checker (
   input  logic clock,
   input  logic reset,
   nlp_req_if   req_mon,
   nlp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   numbers_checked,
   output int   rejects_checked,
   output int   fractions_checked,
   output int   wraps_checked
);

   typedef enum logic [10:0] {
      ST_SKIP_WS     = 11'b000_0000_0001,
      ST_AFTER_SIGN  = 11'b000_0000_0010,
      ST_SIGNED_ZERO = 11'b000_0000_0100,
      ST_LEAD_ZERO   = 11'b000_0000_1000,
      ST_DEC         = 11'b000_0001_0000,
      ST_BIN         = 11'b000_0010_0000,
      ST_OCT         = 11'b000_0100_0000,
      ST_HEX         = 11'b000_1000_0000,
      ST_FRAC        = 11'b001_0000_0000,
      ST_INT_SUFFIX  = 11'b010_0000_0000,
      ST_FRAC_SUFFIX = 11'b100_0000_0000
   } parse_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        negative;
      logic [63:0] magnitude;
      logic [7:0]  frac_digits;
      logic [31:0] end_position;
      logic        overflow;
   } number_type;

   parse_state_type state;
   logic [63:0]     acc;
   logic [7:0]      frac_count;
   logic            minus;
   logic [1:0]      scale;
   logic            wrapped;
   logic [31:0]     stream_pos;

   number_type expected_numbers[$];
   int         fails, checked, rejects, fractions, wraps;

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || c == "\t" || c == "\n" || c == "\r" ||
             c == nlp_tb_pkg::VTAB || c == nlp_tb_pkg::FFEED;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int hex_val(input logic [7:0] c);
      if (is_dec(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic [1:0] suffix_of(input logic [7:0] c);
      if (c == "k" || c == "K") return nlp_pkg::SFX_KILO;
      if (c == "m" || c == "M") return nlp_pkg::SFX_MEGA;
      if (c == "g" || c == "G") return nlp_pkg::SFX_GIGA;
      return nlp_pkg::SFX_NONE;
   endfunction

   // a*m+d modulo 2^64; any carry out of 64 bits marks the number as wrapped
   function automatic logic [63:0] scale_add(input logic [63:0] a, input logic [63:0] m,
                                             input logic [63:0] d);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, m} + {64'd0, d};
      if (full[127:64] != '0) wrapped = 1'b1;
      return full[63:0];
   endfunction

   function automatic logic [63:0] dec_factor(input logic [1:0] s);
      case (s)
         nlp_pkg::SFX_KILO: return 64'd1000;
         nlp_pkg::SFX_MEGA: return 64'd1000 * 64'd1000;
         nlp_pkg::SFX_GIGA: return 64'd1000 * 64'd1000 * 64'd1000;
         default:           return 64'd1;
      endcase
   endfunction

   task automatic restart_number();
      state      = ST_SKIP_WS;
      acc        = '0;
      frac_count = '0;
      minus      = 1'b0;
      scale      = nlp_pkg::SFX_NONE;
      wrapped    = 1'b0;
   endtask

   task automatic parse_char(input logic [7:0] c);
      logic [31:0] at;
      logic [31:0] end_at;
      logic [1:0]  sfx;
      logic [1:0]  kind;
      logic        done;
      int          hv;
      number_type  num;
      at         = stream_pos;
      end_at     = at;
      sfx        = suffix_of(c);
      kind       = nlp_pkg::KIND_NONE;
      done       = 1'b0;
      hv         = hex_val(c);
      stream_pos = at + 32'd1;
      case (state)
         ST_SKIP_WS: begin
            if (c == "-") begin
               minus = 1'b1;
               state = ST_AFTER_SIGN;
            end else if (c == "+") state = ST_AFTER_SIGN;
            else if (c == ".") state = ST_FRAC;
            else if (c == "0") state = ST_LEAD_ZERO;
            else if (is_dec(c)) begin
               acc   = 64'(c - "0");
               state = ST_DEC;
            end else if (!is_space(c)) done = 1'b1;
         end
         ST_AFTER_SIGN: begin
            if (c == "0") state = ST_SIGNED_ZERO;
            else if (c == ".") state = ST_FRAC;
            else if (is_dec(c)) begin
               acc   = 64'(c - "0");
               state = ST_DEC;
            end else done = 1'b1;
         end
         ST_SIGNED_ZERO: begin
            if (c == ".") state = ST_FRAC;
            else if (c != "0") done = 1'b1;
         end
         ST_LEAD_ZERO: begin
            if (c == "x" || c == "X") state = ST_HEX;
            else if (c == "b" || c == "B") state = ST_BIN;
            else if (c == ".") state = ST_FRAC;
            else if (c == nlp_tb_pkg::NUL) begin
               done = 1'b1;
               kind = nlp_pkg::KIND_UINT;
            end else if (sfx != nlp_pkg::SFX_NONE) begin
               scale = sfx;
               state = ST_INT_SUFFIX;
            end else if (c >= "0" && c <= "7") begin
               acc   = 64'(c - "0");
               state = ST_OCT;
            end else done = 1'b1;
         end
         ST_DEC, ST_BIN, ST_OCT, ST_HEX: begin
            if (state == ST_DEC && is_dec(c))
               acc = scale_add(acc, 64'd10, 64'(hv));
            else if (state == ST_DEC && c == ".") state = ST_FRAC;
            else if (state == ST_BIN && (c == "0" || c == "1"))
               acc = scale_add(acc, 64'd2, 64'(hv));
            else if (state == ST_OCT && c >= "0" && c <= "7")
               acc = scale_add(acc, 64'd8, 64'(hv));
            else if (state == ST_HEX && hv >= 0)
               acc = scale_add(acc, 64'd16, 64'(hv));
            else if (sfx != nlp_pkg::SFX_NONE) begin
               scale = sfx;
               state = ST_INT_SUFFIX;
            end else if (is_space(c) || c == nlp_tb_pkg::NUL) begin
               done = 1'b1;
               kind = minus ? nlp_pkg::KIND_NINT : nlp_pkg::KIND_UINT;
            end else done = 1'b1;
         end
         ST_FRAC: begin
            if (is_dec(c)) begin
               acc = scale_add(acc, 64'd10, 64'(hv));
               if (frac_count != 8'hFF) frac_count++;
            end else if (sfx != nlp_pkg::SFX_NONE) begin
               scale = sfx;
               state = ST_FRAC_SUFFIX;
            end else if (is_space(c) || c == nlp_tb_pkg::NUL) begin
               done = 1'b1;
               kind = nlp_pkg::KIND_FRAC;
            end else done = 1'b1;
         end
         ST_INT_SUFFIX, ST_FRAC_SUFFIX: begin
            // i/I picks the binary power and is itself consumed
            if (c == "i" || c == "I") begin
               acc    = scale_add(acc, 64'd1 << (10 * scale), 64'd0);
               end_at = at + 32'd1;
            end else acc = scale_add(acc, dec_factor(scale), 64'd0);
            done = 1'b1;
            kind = (state == ST_FRAC_SUFFIX) ? nlp_pkg::KIND_FRAC :
                   (minus ? nlp_pkg::KIND_NINT : nlp_pkg::KIND_UINT);
         end
         default: done = 1'b1;
      endcase
      if (done) begin
         num.kind         = kind;
         num.negative     = (kind != nlp_pkg::KIND_NONE) ? minus : 1'b0;
         num.magnitude    = (kind != nlp_pkg::KIND_NONE) ? acc : '0;
         num.frac_digits  = (kind == nlp_pkg::KIND_FRAC) ? frac_count : '0;
         num.end_position = end_at;
         num.overflow     = (kind != nlp_pkg::KIND_NONE) ? wrapped : 1'b0;
         expected_numbers.push_back(num);
         restart_number();
      end
   endtask

   always @(posedge clock) begin
      number_type got;
      number_type want;
      if (reset) begin
         restart_number();
         stream_pos = '0;
         expected_numbers.delete();
         fails     = 0;
         checked   = 0;
         rejects   = 0;
         fractions = 0;
         wraps     = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) parse_char(req_mon.char_code);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.kind, rsp_mon.negative, rsp_mon.magnitude,
                   rsp_mon.frac_digits, rsp_mon.end_position, rsp_mon.overflow};
            if (expected_numbers.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected number: kind=%0d neg=%0d mag=%h frac=%0d end=%0d ovf=%0d",
                           got.kind, got.negative, got.magnitude, got.frac_digits,
                           got.end_position, got.overflow);
            end else begin
               want = expected_numbers.pop_front();
               checked++;
               if (want.kind == nlp_pkg::KIND_NONE) rejects++;
               if (want.kind == nlp_pkg::KIND_FRAC) fractions++;
               if (want.overflow) wraps++;
               if (got !== want) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch on number %0d:", checked);
                     $display("  expected kind=%0d neg=%0d mag=%h frac=%0d end=%0d ovf=%0d",
                              want.kind, want.negative, want.magnitude, want.frac_digits,
                              want.end_position, want.overflow);
                     $display("  actual   kind=%0d neg=%0d mag=%h frac=%0d end=%0d ovf=%0d",
                              got.kind, got.negative, got.magnitude, got.frac_digits,
                              got.end_position, got.overflow);
                  end
               end
            end
         end
      end
      fail_count        <= fails;
      pending           <= expected_numbers.size();
      numbers_checked   <= checked;
      rejects_checked   <= rejects;
      fractions_checked <= fractions;
      wraps_checked     <= wraps;
   end

endmodule

[sim/tb_top.sv]
// tb_top: stimulus and verdict for numeric_literal_parser.
// Depends on nlp_pkg, nlp_tb_pkg, nlp_req_if, nlp_rsp_if, nlp_number_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int CHAR_TARGET  = 1400;   // characters after the directed cases
   localparam int STALL_LIMIT  = 5000;   // quiet cycles before the watchdog fires
   localparam int DRAIN_CYCLES = 16;     // queue + result register + suffix cycles, with margin

   logic clock;
   logic reset;

   nlp_req_if req_if ();
   nlp_rsp_if rsp_if ();

   int fail_count, pending, numbers_checked, rejects_checked, fractions_checked, wraps_checked;

   // pacing: percent of cycles in which each side holds off
   int send_idle_pct  = 31;
   int ready_idle_pct = 83;
   int chars_sent     = 0;

   logic [7:0] text[$];   // characters waiting to be sent

   numeric_literal_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   nlp_number_checker number_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .fail_count        (fail_count),
      .pending           (pending),
      .numbers_checked   (numbers_checked),
      .rejects_checked   (rejects_checked),
      .fractions_checked (fractions_checked),
      .wraps_checked     (wraps_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: ready toggles at random at the current pacing
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= reset ? 1'b0 : ($urandom_range(99) >= ready_idle_pct);
      end
   end

   // Watchdog: any cycle with a transfer on either channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d numbers still due",
               STALL_LIMIT, pending);
      $display("[numeric_literal_parser] ERROR");
      $finish;
   end

   // One character transfer. Valid drops only while idling, so a back-to-back
   // transfer never lowers and raises valid in the same step. The ready seen
   // just after the edge is the value the edge itself sampled.
   task automatic send_char(input logic [7:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= code;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text();
      while (text.size() != 0) send_char(text.pop_front());
   endtask

   task automatic push_str(input string s);
      foreach (s[i]) text.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(5))
         0: return " ";
         1: return "\t";
         2: return "\n";
         3: return "\r";
         4: return nlp_tb_pkg::VTAB;
         default: return nlp_tb_pkg::FFEED;
      endcase
   endfunction

   function automatic logic [7:0] dec_char();
      return 8'("0" + $urandom_range(9));
   endfunction

   // what closes a number: whitespace, NUL, or any byte at all
   function automatic logic [7:0] end_char();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return pick_space();
      if (sel < 8) return nlp_tb_pkg::NUL;
      return 8'($urandom_range(255));
   endfunction

   // One random token: mostly well-formed literals of every base, with sign,
   // suffix and terminator mixed in; the rest is noise and sign/zero oddities.
   task automatic add_number();
      string hex_digits;
      string suffixes;
      int    form;
      int    len;
      int    sel;
      hex_digits = "0123456789abcdefABCDEF";
      suffixes   = "kKmMgG";
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) text.push_back(pick_space());
      form = $urandom_range(99);
      // long digit runs push the accumulator past 64 bits
      len  = ($urandom_range(9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 6);
      if (form < 12) begin
         repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
      end else begin
         sel = $urandom_range(9);
         if (sel < 2) text.push_back("-");
         else if (sel == 2) text.push_back("+");
         if (form < 40) begin
            text.push_back(8'("1" + $urandom_range(8)));
            repeat (len - 1) text.push_back(dec_char());
         end else if (form < 52) begin
            text.push_back("0");
            text.push_back($urandom_range(1) ? "x" : "X");
            repeat (len) text.push_back(hex_digits[$urandom_range(21)]);
         end else if (form < 62) begin
            text.push_back("0");
            text.push_back($urandom_range(1) ? "b" : "B");
            repeat ((len > 6) ? len * 3 : len) text.push_back($urandom_range(1) ? "1" : "0");
         end else if (form < 70) begin
            text.push_back("0");
            repeat (len) text.push_back(8'("0" + $urandom_range(7)));
         end else if (form < 90) begin
            sel = $urandom_range(3);
            if (sel == 1) text.push_back("0");
            else if (sel >= 2) begin
               text.push_back(8'("1" + $urandom_range(8)));
               repeat ($urandom_range(3)) text.push_back(dec_char());
            end
            text.push_back(".");
            repeat (len) text.push_back(dec_char());
         end else begin
            repeat ($urandom_range(1, 3)) text.push_back("0");
         end
         if ($urandom_range(99) < 30) begin
            text.push_back(suffixes[$urandom_range(5)]);
            if ($urandom_range(1)) text.push_back($urandom_range(1) ? "i" : "I");
            else text.push_back(end_char());
         end else begin
            text.push_back(end_char());
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.char_code <= nlp_tb_pkg::NUL;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone zero on NUL and on whitespace, signed zero then x,
      // binary suffix on a negative number, fraction with decimal suffix
      // closed by NUL, hex closed by the top character code, plain decimal.
      push_str("0");
      text.push_back(nlp_tb_pkg::NUL);
      push_str("0 ");
      push_str("-0x");
      push_str(" -7Gi");
      push_str(".5m");
      text.push_back(nlp_tb_pkg::NUL);
      push_str("0xF");
      text.push_back(8'hFF);
      push_str("12 ");
      send_text();

      // one fraction long enough to saturate the digit count
      chars_sent = 0;
      text.push_back(".");
      repeat (260) text.push_back(dec_char());
      text.push_back(nlp_tb_pkg::NUL);
      send_text();

      // random part in three pacing phases
      while (chars_sent < CHAR_TARGET) begin
         if (chars_sent < CHAR_TARGET / 3) begin
            send_idle_pct  = 31;
            ready_idle_pct = 83;
         end else if (chars_sent < 2 * CHAR_TARGET / 3) begin
            send_idle_pct  = 83;
            ready_idle_pct = 31;
         end else begin
            send_idle_pct  = 0;
            ready_idle_pct = 0;
         end
         add_number();
         send_text();
      end
      req_if.valid <= 1'b0;

      // let the last prediction land, drain every due number, then a tail
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered directed cases, a saturating fraction and random text, %0d characters",
               chars_sent);
      $display("checked %0d numbers: %0d rejects, %0d fractions, %0d wrapped",
               numbers_checked, rejects_checked, fractions_checked, wraps_checked);
      if (fail_count == 0 && pending == 0)
         $display("[numeric_literal_parser] OK");
      else
         $display("[numeric_literal_parser] ERROR");
      $finish;
   end

endmodule

[numeric_literal_parser.f]
src/nlp_pkg.sv
src/nlp_req_if.sv
src/nlp_rsp_if.sv
src/nlp_front.sv
src/nlp_queue.sv
src/nlp_back.sv
src/numeric_literal_parser.sv
sim/nlp_tb_pkg.sv
sim/nlp_number_checker.sv
sim/tb_top.sv
